// ----- rtl/nlt_pkg.sv -----
// ----------------------------------------------------------------------------
// nlt_pkg
// Types, constants and fixed-point helpers of the nitrogen limited turnover unit
// ----------------------------------------------------------------------------
package nlt_pkg;

  localparam logic [31:0] Q31_ONE  = 32'h8000_0000;
  localparam logic [31:0] RATE_CAP = 32'd214748365;
  localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] INT64_MIN = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    CLS_PASS = 2'd0,
    CLS_DISS = 2'd1,
    CLS_IDLE = 2'd2,
    CLS_NORM = 2'd3
  } cls_e;

  typedef enum logic [1:0] {
    REG_RATE = 2'd0,
    REG_FRAC = 2'd1,
    REG_EFF  = 2'd2,
    REG_MODE = 2'd3
  } reg_e;

  typedef struct packed {
    logic [31:0] base_rate;
    logic [31:0] pool_fraction;
    logic [31:0] digest_efficiency;
    logic        dissolved_mode;
  } cfg_t;

  typedef struct packed {
    logic        active;
    logic [31:0] env_factor;
    logic [63:0] source_c;
    logic [63:0] source_n;
    logic [31:0] target_cn_goal;
    logic [63:0] n_soil;
    logic [63:0] n_used;
  } in_t;

  typedef struct packed {
    logic [63:0]        new_source_c;
    logic [63:0]        new_source_n;
    logic [63:0]        target_c_add;
    logic [63:0]        target_n_add;
    logic [63:0]        co2_add;
    logic signed [63:0] n_used_delta;
    logic               n_limited;
  } out_t;

  // classified item between front and back
  typedef struct packed {
    cls_e        cls;
    logic [31:0] rate;
    logic [63:0] c;
    logic [63:0] n;
    logic [31:0] goal;
    logic [63:0] n_soil;
    logic [63:0] n_used;
  } qitem_t;

  // item state along the back pipeline
  typedef struct packed {
    cls_e        cls;
    logic [31:0] rate;
    logic [63:0] c;
    logic [63:0] n;
    logic [31:0] goal;
    logic [63:0] n_soil;
    logic [63:0] n_used;
    logic [63:0] kept;
    logic [63:0] c_use_r;
    logic [63:0] n_prod_r;
    logic [63:0] k;
    logic [63:0] n_cons_r;
    logic        ok;
    logic        stop;
    logic        kgt;
    logic [63:0] avail;
    logic [63:0] d2;
    logic [31:0] rsel;
    logic [63:0] n_prod;
    logic [63:0] n_cons;
    logic [63:0] c_use;
    logic [63:0] kept2;
    logic [63:0] delta;
    logic        limited;
  } work_t;

  function automatic logic [31:0] sat_q31(input logic [31:0] v);
    sat_q31 = (v > Q31_ONE) ? Q31_ONE : v;
  endfunction

  // floor(a * b / 2^31) for b <= 2^31, as two 32x32 products
  function automatic logic [63:0] mul_q31(input logic [63:0] a, input logic [31:0] b);
    logic [63:0] p_hi;
    logic [63:0] p_lo;
    p_hi    = 64'(a[63:32]) * 64'(b);
    p_lo    = 64'(a[31:0]) * 64'(b);
    mul_q31 = {p_hi[62:0], 1'b0} + (p_lo >> 31);
  endfunction

endpackage

// ----- rtl/nlt_stream_if.sv -----
// ----------------------------------------------------------------------------
// nlt_stream_if
// Valid/ready channel carrying one item
// ----------------------------------------------------------------------------
interface nlt_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/nlt_front.sv -----
// ----------------------------------------------------------------------------
// nlt_front
// Accepts cells, forms the capped rate and classifies the work to be done
// ----------------------------------------------------------------------------
module nlt_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  nlt_stream_if.sink          in_i,
  input  nlt_pkg::cfg_t       cfg_i,
  output logic                push_o,
  output nlt_pkg::qitem_t     push_data_o,
  input  logic                full_i
);

  logic           f0_v_q, f0_v_d;
  nlt_pkg::in_t   f0_q;
  logic [31:0]    spd_q;
  logic [63:0]    spd_prod;
  logic [63:0]    rate_prod;
  logic [39:0]    rate_raw;
  logic [31:0]    rate;
  logic           accept;

  assign in_i.ready = !f0_v_q || !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign push_o     = f0_v_q && !full_i;

  assign spd_prod = 64'(nlt_pkg::sat_q31(cfg_i.base_rate))
                  * 64'(nlt_pkg::sat_q31(cfg_i.pool_fraction));

  always_comb begin
    f0_v_d = f0_v_q;
    if (accept) begin
      f0_v_d = 1'b1;
    end else if (push_o) begin
      f0_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f0_v_q <= 1'b0;
    end else begin
      f0_v_q <= f0_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f0_q  <= in_i.data;
      spd_q <= spd_prod[62:31];
    end
  end

  assign rate_prod = 64'(spd_q) * 64'(f0_q.env_factor);
  assign rate_raw  = rate_prod[63:24];
  assign rate      = (rate_raw > 40'(nlt_pkg::RATE_CAP)) ? nlt_pkg::RATE_CAP : rate_raw[31:0];

  always_comb begin
    push_data_o.rate   = rate;
    push_data_o.c      = f0_q.source_c;
    push_data_o.n      = f0_q.source_n;
    push_data_o.goal   = f0_q.target_cn_goal;
    push_data_o.n_soil = f0_q.n_soil;
    push_data_o.n_used = f0_q.n_used;
    if (!f0_q.active) begin
      push_data_o.cls = nlt_pkg::CLS_PASS;
    end else if (cfg_i.dissolved_mode) begin
      push_data_o.cls = nlt_pkg::CLS_DISS;
    end else if (f0_q.source_c == 64'd0 || rate == 32'd0 || f0_q.target_cn_goal == 32'd0) begin
      push_data_o.cls = nlt_pkg::CLS_IDLE;
    end else begin
      push_data_o.cls = nlt_pkg::CLS_NORM;
    end
  end

endmodule

// ----- rtl/nlt_queue.sv -----
// ----------------------------------------------------------------------------
// nlt_queue
// Two-entry queue between the front and the back
// ----------------------------------------------------------------------------
module nlt_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  nlt_pkg::qitem_t push_data_i,
  output logic            full_o,
  output logic            valid_o,
  output nlt_pkg::qitem_t data_o,
  input  logic            pop_i
);

  nlt_pkg::qitem_t mem_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/nlt_div.sv -----
// ----------------------------------------------------------------------------
// nlt_div
// Pipelined restoring divider, one quotient bit per stage, saturating
// ----------------------------------------------------------------------------
module nlt_div #(
  parameter int  DW     = 32,
  parameter type side_t = logic
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [DW-1:0] hi_i,
  input  logic [63:0]   lo_i,
  input  logic [DW-1:0] d_i,
  input  side_t         side_i,
  output logic          vld_o,
  output logic [63:0]   q_o,
  output side_t         side_o
);

  localparam int NSTAGE = 64;

  logic          vld_q  [1:NSTAGE];
  logic [DW-1:0] rem_q  [1:NSTAGE];
  logic [63:0]   lo_q   [1:NSTAGE];
  logic [63:0]   quo_q  [1:NSTAGE];
  logic [DW-1:0] d_q    [1:NSTAGE];
  logic          sat_q  [1:NSTAGE];
  side_t         side_q [1:NSTAGE];

  for (genvar i = 1; i <= NSTAGE; i++) begin : g_stage
    logic          p_vld;
    logic [DW-1:0] p_rem;
    logic [63:0]   p_lo;
    logic [63:0]   p_quo;
    logic [DW-1:0] p_d;
    logic          p_sat;
    side_t         p_side;
    logic [DW:0]   trial;
    logic          ge;

    if (i == 1) begin : g_first
      assign p_vld  = vld_i;
      assign p_rem  = hi_i;
      assign p_lo   = lo_i;
      assign p_quo  = 64'd0;
      assign p_d    = d_i;
      assign p_sat  = hi_i >= d_i;
      assign p_side = side_i;
    end else begin : g_next
      assign p_vld  = vld_q[i-1];
      assign p_rem  = rem_q[i-1];
      assign p_lo   = lo_q[i-1];
      assign p_quo  = quo_q[i-1];
      assign p_d    = d_q[i-1];
      assign p_sat  = sat_q[i-1];
      assign p_side = side_q[i-1];
    end

    assign trial = {p_rem, p_lo[63]};
    assign ge    = trial >= {1'b0, p_d};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= p_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= ge ? DW'(trial - {1'b0, p_d}) : trial[DW-1:0];
        lo_q[i]   <= {p_lo[62:0], 1'b0};
        quo_q[i]  <= {p_quo[62:0], ge};
        d_q[i]    <= p_d;
        sat_q[i]  <= p_sat;
        side_q[i] <= p_side;
      end
    end
  end

  assign vld_o  = vld_q[NSTAGE];
  assign q_o    = sat_q[NSTAGE] ? {64{1'b1}} : quo_q[NSTAGE];
  assign side_o = side_q[NSTAGE];

endmodule

// ----- rtl/nlt_back.sv -----
// ----------------------------------------------------------------------------
// nlt_back
// Turnover pipeline: goal-ratio division, nitrogen check, rate cut, fluxes
// ----------------------------------------------------------------------------
module nlt_back #(
  parameter int AMOUNT_FRAC_BITS = 48
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  nlt_pkg::qitem_t q_data_i,
  output logic            pop_o,
  input  logic [31:0]     eff_i,
  nlt_stream_if.source    out_o
);

  localparam logic [63:0] RESERVE =
    64'((65'd1 << AMOUNT_FRAC_BITS) / 65'd1000000000000);

  logic            en;
  logic            s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, s6_v_q, s7_v_q, out_v_q;
  logic            d1_v, d2_v;
  logic [63:0]     d1_q, d2_q;
  nlt_pkg::work_t  s1_q, s2_q, s3_q, s4_q, s5_q, s6_q, s7_q;
  nlt_pkg::work_t  s1_d, s2_d, s3_d, s4_d, s5_d, s6_d, s7_d;
  nlt_pkg::work_t  d1_side, d2_side;
  nlt_pkg::out_t   out_q, out_d;

  assign en    = !out_v_q || out_o.ready;
  assign pop_o = en && q_valid_i;

  always_comb begin
    s1_d        = '0;
    s1_d.cls    = q_data_i.cls;
    s1_d.rate   = q_data_i.rate;
    s1_d.c      = q_data_i.c;
    s1_d.n      = q_data_i.n;
    s1_d.goal   = q_data_i.goal;
    s1_d.n_soil = q_data_i.n_soil;
    s1_d.n_used = q_data_i.n_used;
  end

  always_comb begin
    s2_d          = s1_q;
    s2_d.kept     = nlt_pkg::mul_q31(s1_q.c, eff_i);
    s2_d.c_use_r  = nlt_pkg::mul_q31(s1_q.c, s1_q.rate);
    s2_d.n_prod_r = nlt_pkg::mul_q31(s1_q.n, s1_q.rate);
  end

  // nitrogen needed at full rate: kept carbon over the goal ratio
  nlt_div #(.DW(32), .side_t(nlt_pkg::work_t)) u_div_goal (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s2_v_q),
    .hi_i   ({16'd0, s2_q.kept[63:48]}),
    .lo_i   ({s2_q.kept[47:0], 16'd0}),
    .d_i    (s2_q.goal),
    .side_i (s2_q),
    .vld_o  (d1_v),
    .q_o    (d1_q),
    .side_o (d1_side)
  );

  always_comb begin
    s3_d          = d1_side;
    s3_d.k        = d1_q;
    s3_d.n_cons_r = nlt_pkg::mul_q31(d1_q, d1_side.rate);
  end

  always_comb begin
    logic [64:0] lhs;
    logic [64:0] rhs;
    logic [64:0] t;
    lhs       = {1'b0, s3_q.n_cons_r} + {1'b0, s3_q.n_used};
    rhs       = {1'b0, s3_q.n_prod_r} + {1'b0, s3_q.n_soil};
    t         = {1'b0, s3_q.n_used} + {1'b0, RESERVE};
    s4_d      = s3_q;
    s4_d.ok   = lhs < rhs;
    s4_d.stop = t[64] || (s3_q.n_soil <= t[63:0]);
    s4_d.avail = s3_q.n_soil - t[63:0];
    s4_d.kgt  = s3_q.k > s3_q.n;
    s4_d.d2   = s3_q.k - s3_q.n;
  end

  // rate that leaves only the reserve of soil nitrogen unused
  nlt_div #(.DW(64), .side_t(nlt_pkg::work_t)) u_div_rate (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s4_v_q),
    .hi_i   ({33'd0, s4_q.avail[63:33]}),
    .lo_i   ({s4_q.avail[32:0], 31'd0}),
    .d_i    (s4_q.d2),
    .side_i (s4_q),
    .vld_o  (d2_v),
    .q_o    (d2_q),
    .side_o (d2_side)
  );

  always_comb begin
    logic [63:0] r2;
    logic [31:0] r2c;
    r2   = d2_side.kgt ? d2_q : 64'd0;
    r2c  = (r2 > 64'(d2_side.rate)) ? d2_side.rate : r2[31:0];
    s5_d = d2_side;
    s5_d.limited = !d2_side.ok;
    if (d2_side.ok) begin
      s5_d.rsel = d2_side.rate;
    end else if (d2_side.stop) begin
      s5_d.rsel = 32'd0;
    end else begin
      s5_d.rsel = r2c;
    end
  end

  always_comb begin
    s6_d        = s5_q;
    s6_d.n_prod = nlt_pkg::mul_q31(s5_q.n, s5_q.rsel);
    s6_d.n_cons = nlt_pkg::mul_q31(s5_q.k, s5_q.rsel);
    s6_d.c_use  = nlt_pkg::mul_q31(s5_q.c, s5_q.rsel);
  end

  always_comb begin
    logic [63:0] diff;
    s7_d       = s6_q;
    s7_d.kept2 = nlt_pkg::mul_q31(s6_q.c_use, eff_i);
    if (s6_q.n_cons >= s6_q.n_prod) begin
      diff       = s6_q.n_cons - s6_q.n_prod;
      s7_d.delta = diff[63] ? nlt_pkg::INT64_MAX : diff;
    end else begin
      diff       = s6_q.n_prod - s6_q.n_cons;
      s7_d.delta = diff[63] ? nlt_pkg::INT64_MIN : 64'd0 - diff;
    end
  end

  always_comb begin
    out_d              = '0;
    out_d.new_source_c = s7_q.c;
    out_d.new_source_n = s7_q.n;
    case (s7_q.cls)
      nlt_pkg::CLS_DISS: begin
        out_d.new_source_c = s7_q.c - s7_q.c_use_r;
        out_d.new_source_n = s7_q.n - s7_q.n_prod_r;
        out_d.target_c_add = s7_q.c_use_r;
        out_d.target_n_add = s7_q.n_prod_r;
      end
      nlt_pkg::CLS_NORM: begin
        out_d.new_source_c = s7_q.c - s7_q.c_use;
        out_d.new_source_n = s7_q.n - s7_q.n_prod;
        out_d.target_c_add = s7_q.kept2;
        out_d.target_n_add = s7_q.n_cons;
        out_d.co2_add      = s7_q.c_use - s7_q.kept2;
        out_d.n_used_delta = s7_q.delta;
        out_d.n_limited    = s7_q.limited;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      s5_v_q  <= 1'b0;
      s6_v_q  <= 1'b0;
      s7_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q  <= pop_o;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= d1_v;
      s4_v_q  <= s3_v_q;
      s5_v_q  <= d2_v;
      s6_v_q  <= s5_v_q;
      s7_v_q  <= s6_v_q;
      out_v_q <= s7_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q  <= s1_d;
      s2_q  <= s2_d;
      s3_q  <= s3_d;
      s4_q  <= s4_d;
      s5_q  <= s5_d;
      s6_q  <= s6_d;
      s7_q  <= s7_d;
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

endmodule

// ----- rtl/nitrogen_limited_turnover_unit.sv -----
// ----------------------------------------------------------------------------
// nitrogen_limited_turnover_unit
// Nitrogen limited turnover of one organic pool, one soil cell per item
// ----------------------------------------------------------------------------
//   channel   dir  handshake            payload
//   in_i      in   valid/ready          nlt_pkg::in_t  (one soil cell)
//   out_o     out  valid/ready          nlt_pkg::out_t (fluxes and new pool)
//   apb       in   psel/penable/pwrite  four registers at 4*index
//
// one item per cycle sustained while the output is not stalled; the result
// passes the front register, the queue, the back stages and the two
// 64-stage dividers (goal ratio, then the nitrogen-limited rate)
// reset clears all valid bits and loads the register reset values
// a stalled output freezes the back pipeline; the front and queue keep
// taking items until the two-entry queue is full
// ----------------------------------------------------------------------------
module nitrogen_limited_turnover_unit #(
  parameter int AMOUNT_FRAC_BITS = 48
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  nlt_stream_if.sink   in_i,
  nlt_stream_if.source out_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [31:0]     rate_q;
  logic [31:0]     frac_q;
  logic [31:0]     eff_q;
  logic            mode_q;
  logic            cfg_wr;
  nlt_pkg::reg_e   reg_idx;
  nlt_pkg::cfg_t   cfg;
  logic            push;
  nlt_pkg::qitem_t push_data;
  logic            full;
  logic            q_valid;
  nlt_pkg::qitem_t q_data;
  logic            pop;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = nlt_pkg::reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= 32'd0;
      frac_q <= 32'd0;
      eff_q  <= nlt_pkg::Q31_ONE;
      mode_q <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        nlt_pkg::REG_RATE: rate_q <= pwdata;
        nlt_pkg::REG_FRAC: frac_q <= pwdata;
        nlt_pkg::REG_EFF:  eff_q  <= pwdata;
        nlt_pkg::REG_MODE: mode_q <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      nlt_pkg::REG_RATE: prdata = rate_q;
      nlt_pkg::REG_FRAC: prdata = frac_q;
      nlt_pkg::REG_EFF:  prdata = eff_q;
      nlt_pkg::REG_MODE: prdata = {31'd0, mode_q};
      default:           prdata = 32'd0;
    endcase
  end

  always_comb begin
    cfg.base_rate         = rate_q;
    cfg.pool_fraction     = frac_q;
    cfg.digest_efficiency = eff_q;
    cfg.dissolved_mode    = mode_q;
  end

  nlt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  nlt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .valid_o     (q_valid),
    .data_o      (q_data),
    .pop_i       (pop)
  );

  nlt_back #(.AMOUNT_FRAC_BITS(AMOUNT_FRAC_BITS)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .pop_o     (pop),
    .eff_i     (nlt_pkg::sat_q31(eff_q)),
    .out_o     (out_o)
  );

endmodule

// ----- rtl/nlt_checker.sv -----
// ----------------------------------------------------------------------------
// nlt_checker
// Port-level checks of the nitrogen limited turnover unit
// ----------------------------------------------------------------------------
module nlt_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input nlt_pkg::out_t out_data_i,
  input logic          psel,
  input logic          pwrite,
  input logic [3:0]    paddr,
  input logic [31:0]   prdata
);

  // a result waiting on the sink holds its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result dropped or changed while stalled");

  // all valid bits are reset and the output is registered, so nothing comes out right after reset
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("result right after reset");

  // the mode register is a single bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && !pwrite && paddr[3:2] == nlt_pkg::REG_MODE |-> prdata[31:1] == 31'd0)
    else $error("mode register reads back more than one bit");

  // limited cells without carbon flux add target nitrogen only with nonzero use delta or pool n
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.n_limited && out_data_i.co2_add == 64'd0 &&
    out_data_i.target_c_add == 64'd0 |-> out_data_i.target_n_add == 64'd0 ||
    out_data_i.n_used_delta != 64'sd0 || out_data_i.new_source_n != 64'd0)
    else $error("limited cell with inconsistent nitrogen");

endmodule

bind nitrogen_limited_turnover_unit nlt_checker u_nlt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data),
  .psel        (psel),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .prdata      (prdata)
);
